@@ hw/rtl/ept_pkg.sv @@
// Package with shared types, constants and arithmetic helpers for the pose-to-transform block.
package ept_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int FRAC_BITS     = 14;
  localparam int IQ            = 30;
  localparam int Q_W           = 32;
  localparam int ANGLE_W       = 16;
  localparam int TRANS_W       = 32;
  localparam int ENTRY_W       = 16;
  localparam int ATAN_LEN      = 24;
  localparam int LANES         = 3;

  localparam int CORDIC_RUN = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;

  localparam logic signed [Q_W-1:0] CORDIC_GAIN_Q30 = 32'sd652032874;

  localparam logic signed [63:0] MUL_HALF = 64'sd1 <<< (IQ - 1);

  localparam int ROUND_SH = IQ - FRAC_BITS;
  localparam logic signed [34:0] ROUND_HALF =
    (ROUND_SH > 0) ? (35'sd1 <<< (ROUND_SH - 1)) : 35'sd0;
  localparam logic signed [34:0] ENTRY_LIM = 35'sd1 <<< FRAC_BITS;

  typedef logic signed [Q_W-1:0]     q30_t;
  typedef logic signed [ENTRY_W-1:0] entry_t;
  typedef logic signed [TRANS_W-1:0] trans_val_t;

  typedef struct packed {
    q30_t cx;
    q30_t sx;
    q30_t cy;
    q30_t sy;
    q30_t cz;
    q30_t sz;
  } ept_trig_t;

  typedef struct packed {
    trans_val_t x;
    trans_val_t y;
    trans_val_t z;
  } ept_trans_t;

  typedef struct packed {
    entry_t     r00;
    entry_t     r01;
    entry_t     r02;
    entry_t     r10;
    entry_t     r11;
    entry_t     r12;
    entry_t     r20;
    entry_t     r21;
    entry_t     r22;
    ept_trans_t trans;
  } ept_xform_t;

  // Arctangent of 2^-i in phase units, where 2^32 is one full turn.
  function automatic q30_t atan_phase(input int idx);
    q30_t a;
    case (idx)
      0:       a = 32'sh20000000;
      1:       a = 32'sh12E4051E;
      2:       a = 32'sh09FB385B;
      3:       a = 32'sh051111D4;
      4:       a = 32'sh028B0D43;
      5:       a = 32'sh0145D7E1;
      6:       a = 32'sh00A2F61E;
      7:       a = 32'sh00517C55;
      8:       a = 32'sh0028BE53;
      9:       a = 32'sh00145F2F;
      10:      a = 32'sh000A2F98;
      11:      a = 32'sh000517CC;
      12:      a = 32'sh00028BE6;
      13:      a = 32'sh000145F3;
      14:      a = 32'sh0000A2FA;
      15:      a = 32'sh0000517D;
      16:      a = 32'sh000028BE;
      17:      a = 32'sh0000145F;
      18:      a = 32'sh00000A30;
      19:      a = 32'sh00000518;
      20:      a = 32'sh0000028C;
      21:      a = 32'sh00000146;
      22:      a = 32'sh000000A3;
      23:      a = 32'sh00000051;
      default: a = '0;
    endcase
    return a;
  endfunction

  // Q.30 product rounded half up back to Q.30.
  function automatic q30_t mulq(input q30_t a, input q30_t b);
    logic signed [63:0] p;
    p = $signed({{(64-Q_W){a[Q_W-1]}}, a}) * $signed({{(64-Q_W){b[Q_W-1]}}, b});
    p = p + MUL_HALF;
    return p[IQ +: Q_W];
  endfunction

  function automatic logic signed [Q_W:0] ext_q(input q30_t v);
    return {v[Q_W-1], v};
  endfunction

  // Rounds a Q.30 sum to FRAC_BITS and clamps it to plus or minus one.
  function automatic entry_t finish_entry(input logic signed [Q_W:0] v);
    logic signed [34:0] t;
    t = ($signed({{2{v[Q_W]}}, v}) + ROUND_HALF) >>> ROUND_SH;
    if (t > ENTRY_LIM) begin
      t = ENTRY_LIM;
    end else if (t < -ENTRY_LIM) begin
      t = -ENTRY_LIM;
    end
    return t[ENTRY_W-1:0];
  endfunction

endpackage

@@ hw/rtl/euler_pose_to_transform.sv @@
// Top level: roll, pitch, yaw pose to a 3x4 rotation and translation transform.
// The pipeline has one fold stage, one stage per CORDIC iteration, one sign stage
// and three product and rounding stages, and every stage holds its own valid bit.
// Throughput is one request per cycle when the output is not stalled.
// Reset clears the valid bits only; payload registers are not reset.
module euler_pose_to_transform
  import ept_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // trans_x, trans_y, trans_z, roll_angle, pitch_angle, yaw_angle
  input  logic [143:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // r00, r01, r02, r10, r11, r12, r20, r21, r22, out_x, out_y, out_z
  output logic [239:0] m_axis_tdata
);

  ept_trans_t in_trans;
  ept_trans_t sc_trans;
  ept_trig_t  sc_trig;
  logic       sc_valid;
  logic       sc_ready;
  ept_xform_t xf;

  assign in_trans.x = s_axis_tdata[31:0];
  assign in_trans.y = s_axis_tdata[63:32];
  assign in_trans.z = s_axis_tdata[95:64];

  ept_sincos u_sincos (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .roll_angle  (s_axis_tdata[111:96]),
    .pitch_angle (s_axis_tdata[127:112]),
    .yaw_angle   (s_axis_tdata[143:128]),
    .in_trans    (in_trans),
    .out_valid   (sc_valid),
    .out_ready   (sc_ready),
    .out_trig    (sc_trig),
    .out_trans   (sc_trans)
  );

  ept_matrix u_matrix (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sc_valid),
    .in_ready  (sc_ready),
    .in_trig   (sc_trig),
    .in_trans  (sc_trans),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_xf    (xf)
  );

  assign m_axis_tdata = {xf.trans.z, xf.trans.y, xf.trans.x,
                         xf.r22, xf.r21, xf.r20, xf.r12, xf.r11, xf.r10,
                         xf.r02, xf.r01, xf.r00};

  a_ready_chain: assert property (@(posedge clk) disable iff (rst)
    m_axis_tready |-> s_axis_tready)
    else $error("Input side stalled while the output side is draining.");

endmodule

@@ hw/rtl/ept_sincos.sv @@
// Pipelined CORDIC that forms sine and cosine of the three pose angles.
module ept_sincos
  import ept_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [ANGLE_W-1:0] roll_angle,
  input  logic signed [ANGLE_W-1:0] pitch_angle,
  input  logic signed [ANGLE_W-1:0] yaw_angle,
  input  ept_trans_t                in_trans,
  output logic                      out_valid,
  input  logic                      out_ready,
  output ept_trig_t                 out_trig,
  output ept_trans_t                out_trans
);

  localparam int NS = CORDIC_RUN;
  localparam q30_t ZQ = 32'sh40000000;

  logic [ANGLE_W-1:0] ang [LANES];

  logic       vld  [NS+1];
  logic       rdy  [NS+2];
  q30_t       xs   [NS+1][LANES];
  q30_t       ys   [NS+1][LANES];
  q30_t       zs   [NS+1][LANES];
  logic       flip [NS+1][LANES];
  ept_trans_t tr   [NS+1];

  q30_t       cos_q [LANES];
  q30_t       sin_q [LANES];
  ept_trans_t tr_q;

  assign ang[0] = roll_angle;
  assign ang[1] = pitch_angle;
  assign ang[2] = yaw_angle;

  assign rdy[NS+1] = !out_valid || out_ready;
  assign in_ready  = rdy[0];

  genvar k;
  generate
    for (k = 0; k <= NS; k++) begin : g_rdy
      assign rdy[k] = !vld[k] || rdy[k+1];
    end
  endgenerate

  // Fold the angle into the right half plane and load the start vector.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (rdy[0]) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && in_valid) begin
      for (int l = 0; l < LANES; l++) begin
        flip[0][l] <= ang[l][ANGLE_W-1] ^ ang[l][ANGLE_W-2];
        if (ang[l][ANGLE_W-1] ^ ang[l][ANGLE_W-2]) begin
          zs[0][l] <= {~ang[l][ANGLE_W-1], ang[l][ANGLE_W-2:0], {(Q_W-ANGLE_W){1'b0}}};
        end else begin
          zs[0][l] <= {ang[l], {(Q_W-ANGLE_W){1'b0}}};
        end
        xs[0][l] <= CORDIC_GAIN_Q30;
        ys[0][l] <= '0;
      end
      tr[0] <= in_trans;
    end
  end

  generate
    for (k = 1; k <= NS; k++) begin : g_stage
      always_ff @(posedge clk) begin
        if (rst) begin
          vld[k] <= 1'b0;
        end else if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end

      always_ff @(posedge clk) begin
        if (rdy[k] && vld[k-1]) begin
          for (int l = 0; l < LANES; l++) begin
            if (!zs[k-1][l][Q_W-1]) begin
              xs[k][l] <= xs[k-1][l] - (ys[k-1][l] >>> (k-1));
              ys[k][l] <= ys[k-1][l] + (xs[k-1][l] >>> (k-1));
              zs[k][l] <= zs[k-1][l] - atan_phase(k-1);
            end else begin
              xs[k][l] <= xs[k-1][l] + (ys[k-1][l] >>> (k-1));
              ys[k][l] <= ys[k-1][l] - (xs[k-1][l] >>> (k-1));
              zs[k][l] <= zs[k-1][l] + atan_phase(k-1);
            end
            flip[k][l] <= flip[k-1][l];
          end
          tr[k] <= tr[k-1];
        end
      end
    end
  endgenerate

  // Undo the fold by negating both results of a folded angle.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdy[NS+1]) begin
      out_valid <= vld[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[NS+1] && vld[NS]) begin
      for (int l = 0; l < LANES; l++) begin
        cos_q[l] <= flip[NS][l] ? -xs[NS][l] : xs[NS][l];
        sin_q[l] <= flip[NS][l] ? -ys[NS][l] : ys[NS][l];
      end
      tr_q <= tr[NS];
    end
  end

  assign out_trig.cx = cos_q[0];
  assign out_trig.sx = sin_q[0];
  assign out_trig.cy = cos_q[1];
  assign out_trig.sy = sin_q[1];
  assign out_trig.cz = cos_q[2];
  assign out_trig.sz = sin_q[2];
  assign out_trans   = tr_q;

  a_fold_range: assert property (@(posedge clk) disable iff (rst)
    vld[0] |-> (zs[0][0] >= -ZQ && zs[0][0] < ZQ && zs[0][1] >= -ZQ && zs[0][1] < ZQ &&
                zs[0][2] >= -ZQ && zs[0][2] < ZQ))
    else $error("Folded phase left the right half plane.");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !vld[0])
    else $error("Pipeline holds a request right after reset.");

endmodule

@@ hw/rtl/ept_matrix.sv @@
// Three-stage product and rounding pipeline that builds the rotation entries.
module ept_matrix
  import ept_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  ept_trig_t  in_trig,
  input  ept_trans_t in_trans,
  output logic       out_valid,
  input  logic       out_ready,
  output ept_xform_t out_xf
);

  logic v1, v2;
  logic rdy1, rdy2, rdy3;

  q30_t czcy1, czsy1, szsy1, szcx1, szsx1, szcy1, czcx1, czsx1, cysx1, cycx1;
  q30_t sx1, cx1, sy1;
  ept_trans_t tr1;

  q30_t p01, p02, p11, p12;
  q30_t czcy2, szcx2, szsx2, szcy2, czcx2, czsx2, cysx2, cycx2, sy2;
  ept_trans_t tr2;

  assign rdy3     = !out_valid || out_ready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1) begin
        v1 <= in_valid;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        out_valid <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      czcy1 <= mulq(in_trig.cz, in_trig.cy);
      czsy1 <= mulq(in_trig.cz, in_trig.sy);
      szsy1 <= mulq(in_trig.sz, in_trig.sy);
      szcx1 <= mulq(in_trig.sz, in_trig.cx);
      szsx1 <= mulq(in_trig.sz, in_trig.sx);
      szcy1 <= mulq(in_trig.sz, in_trig.cy);
      czcx1 <= mulq(in_trig.cz, in_trig.cx);
      czsx1 <= mulq(in_trig.cz, in_trig.sx);
      cysx1 <= mulq(in_trig.cy, in_trig.sx);
      cycx1 <= mulq(in_trig.cy, in_trig.cx);
      sx1   <= in_trig.sx;
      cx1   <= in_trig.cx;
      sy1   <= in_trig.sy;
      tr1   <= in_trans;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      p01   <= mulq(czsy1, sx1);
      p02   <= mulq(czsy1, cx1);
      p11   <= mulq(szsy1, sx1);
      p12   <= mulq(szsy1, cx1);
      czcy2 <= czcy1;
      szcx2 <= szcx1;
      szsx2 <= szsx1;
      szcy2 <= szcy1;
      czcx2 <= czcx1;
      czsx2 <= czsx1;
      cysx2 <= cysx1;
      cycx2 <= cycx1;
      sy2   <= sy1;
      tr2   <= tr1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2) begin
      out_xf.r00   <= finish_entry(ext_q(czcy2));
      out_xf.r01   <= finish_entry(ext_q(p01) - ext_q(szcx2));
      out_xf.r02   <= finish_entry(ext_q(p02) + ext_q(szsx2));
      out_xf.r10   <= finish_entry(ext_q(szcy2));
      out_xf.r11   <= finish_entry(ext_q(p11) + ext_q(czcx2));
      out_xf.r12   <= finish_entry(ext_q(p12) - ext_q(czsx2));
      out_xf.r20   <= finish_entry(-ext_q(sy2));
      out_xf.r21   <= finish_entry(ext_q(cysx2));
      out_xf.r22   <= finish_entry(ext_q(cycx2));
      out_xf.trans <= tr2;
    end
  end

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_xf))
    else $error("Stalled result changed or vanished.");

  a_stage_advance: assert property (@(posedge clk) disable iff (rst)
    v2 && rdy3 |=> out_valid)
    else $error("Result lost between the last two stages.");

endmodule

@@ tb/tb_euler_pose_to_transform.sv @@
// Self-checking testbench for euler_pose_to_transform with a bit-exact rotation predictor.
`timescale 1ns / 100ps

module tb_euler_pose_to_transform
  import ept_pkg::*;
;

  localparam int POSE_W = 3 * TRANS_W + 3 * ANGLE_W;
  localparam int XFORM_W = 9 * ENTRY_W + 3 * TRANS_W;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = CORDIC_STAGES + 15;

  localparam longint ATAN_TURN [24] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
    64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
    64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
  };
  localparam longint GAIN_Q30 = 64'd652032874;

  localparam logic [ANGLE_W-1:0] CORNER_ANGLES [13] = '{
    16'h0000, 16'h0001, 16'hFFFF, 16'h2000, 16'hE000, 16'h3FFF, 16'h4000,
    16'h4001, 16'hC000, 16'hBFFF, 16'h8000, 16'h7FFF, 16'h6000
  };
  localparam logic [TRANS_W-1:0] CORNER_TRANS [6] = '{
    32'h80000000, 32'h7FFFFFFF, 32'h00000000, 32'hFFFFFFFF, 32'h55555555, 32'hAAAAAAAA
  };

  logic               clk;
  logic               rst;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [POSE_W-1:0]  s_axis_tdata;
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [XFORM_W-1:0] m_axis_tdata;

  logic [XFORM_W-1:0] xforms_due [$];
  int                 poses_taken;
  int                 xform_errors;
  int                 stall_cycles;
  bit                 calm;

  euler_pose_to_transform uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic void cordic_sincos(input logic [ANGLE_W-1:0] ang,
                                        output longint c, output longint s);
    logic [31:0] ph;
    logic [31:0] probe;
    bit          flip;
    longint      x;
    longint      y;
    longint      z;
    longint      dx;
    longint      dy;
    ph = {ang, 16'h0000};
    probe = ph + 32'h40000000;
    flip = probe[31];
    if (flip) begin
      ph = ph + 32'h80000000;
    end
    x = GAIN_Q30;
    y = 0;
    z = longint'($signed(ph));
    for (int i = 0; i < CORDIC_STAGES && i < ATAN_LEN; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - ATAN_TURN[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + ATAN_TURN[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic longint qmul(input longint a, input longint b);
    return (a * b + (64'sd1 <<< (IQ - 1))) >>> IQ;
  endfunction

  function automatic logic [ENTRY_W-1:0] round_entry(input longint v);
    longint lim;
    int     sh;
    lim = 64'sd1 <<< FRAC_BITS;
    sh = IQ - FRAC_BITS;
    if (sh > 0) begin
      v = (v + (64'sd1 <<< (sh - 1))) >>> sh;
    end
    if (v > lim) begin
      v = lim;
    end
    if (v < -lim) begin
      v = -lim;
    end
    return v[ENTRY_W-1:0];
  endfunction

  function automatic logic [XFORM_W-1:0] predict_xform(input logic [POSE_W-1:0] pose);
    longint cx, sx, cy, sy, cz, sz, czsy, szsy;
    logic [ENTRY_W-1:0] r [9];
    cordic_sincos(pose[3*TRANS_W +: ANGLE_W], cx, sx);
    cordic_sincos(pose[3*TRANS_W + ANGLE_W +: ANGLE_W], cy, sy);
    cordic_sincos(pose[3*TRANS_W + 2*ANGLE_W +: ANGLE_W], cz, sz);
    czsy = qmul(cz, sy);
    szsy = qmul(sz, sy);
    r[0] = round_entry(qmul(cz, cy));
    r[1] = round_entry(qmul(czsy, sx) - qmul(sz, cx));
    r[2] = round_entry(qmul(czsy, cx) + qmul(sz, sx));
    r[3] = round_entry(qmul(sz, cy));
    r[4] = round_entry(qmul(szsy, sx) + qmul(cz, cx));
    r[5] = round_entry(qmul(szsy, cx) - qmul(cz, sx));
    r[6] = round_entry(-sy);
    r[7] = round_entry(qmul(cy, sx));
    r[8] = round_entry(qmul(cy, cx));
    return {pose[3*TRANS_W-1:0], r[8], r[7], r[6], r[5], r[4], r[3], r[2], r[1], r[0]};
  endfunction

  function automatic logic [POSE_W-1:0] make_pose(input logic [TRANS_W-1:0] tx,
                                                  input logic [TRANS_W-1:0] ty,
                                                  input logic [TRANS_W-1:0] tz,
                                                  input logic [ANGLE_W-1:0] roll,
                                                  input logic [ANGLE_W-1:0] pitch,
                                                  input logic [ANGLE_W-1:0] yaw);
    return {yaw, pitch, roll, tz, ty, tx};
  endfunction

  // Angles cluster near multiples of 45 degrees; the fold switches at 90 and 270.
  function automatic logic [ANGLE_W-1:0] pick_angle();
    if ($urandom_range(9) < 3) begin
      return ANGLE_W'($urandom_range(7) * 8192 + $urandom_range(8) - 4);
    end
    return ANGLE_W'($urandom);
  endfunction

  function automatic logic [TRANS_W-1:0] pick_trans();
    if ($urandom_range(9) == 0) begin
      return CORNER_TRANS[$urandom_range(5)];
    end
    return $urandom;
  endfunction

  // Called and returning just after a falling edge.
  task automatic send_pose(input logic [POSE_W-1:0] pose);
    int target;
    if (!calm && $urandom_range(3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(16, 1)) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= pose;
    target = poses_taken + 1;
    do @(negedge clk); while (poses_taken != target);
  endtask

  task automatic test_corner_angles();
    foreach (CORNER_ANGLES[i]) begin
      send_pose(make_pose(32'h00010000, 32'hFFFF0000, 32'h00000000, CORNER_ANGLES[i],
                          CORNER_ANGLES[12 - i], CORNER_ANGLES[(i + 5) % 13]));
    end
    send_pose(make_pose(32'h0, 32'h0, 32'h0, 16'h1234, 16'h4000, 16'hABCD));
    send_pose(make_pose(32'h0, 32'h0, 32'h0, 16'hE000, 16'hC000, 16'h2000));
  endtask

  task automatic test_translation_passthrough();
    foreach (CORNER_TRANS[i]) begin
      send_pose(make_pose(CORNER_TRANS[i], CORNER_TRANS[(i + 1) % 6],
                          CORNER_TRANS[(i + 3) % 6], 16'h8000, 16'h7FFF, 16'h0000));
    end
  endtask

  task automatic test_random_poses(input int count);
    repeat (count) begin
      send_pose(make_pose(pick_trans(), pick_trans(), pick_trans(),
                          pick_angle(), pick_angle(), pick_angle()));
    end
  endtask

  task automatic test_back_to_back(input int count);
    calm = 1'b1;
    test_random_poses(count);
  endtask

  always @(negedge clk) begin : receiver
    int hold;
    if (calm || rst) begin
      hold = 0;
      m_axis_tready <= 1'b1;
    end else if (hold > 0) begin
      hold = hold - 1;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(7) == 0) begin
      hold = $urandom_range(16, 1) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : scoreboard
    logic [XFORM_W-1:0] due;
    logic [31:0]        want;
    logic [31:0]        got;
    bit                 took_in;
    bit                 took_out;
    took_in = !rst && s_axis_tvalid && s_axis_tready;
    took_out = !rst && m_axis_tvalid && m_axis_tready;
    if (took_out) begin
      if (xforms_due.size() == 0) begin
        xform_errors++;
        if (xform_errors <= 10) begin
          $display("unexpected transform %h", m_axis_tdata);
        end
      end else begin
        due = xforms_due.pop_front();
        for (int f = 0; f < 12; f++) begin
          if (f < 9) begin
            want = 32'(due[ENTRY_W*f +: ENTRY_W]);
            got = 32'(m_axis_tdata[ENTRY_W*f +: ENTRY_W]);
          end else begin
            want = due[9*ENTRY_W + TRANS_W*(f-9) +: TRANS_W];
            got = m_axis_tdata[9*ENTRY_W + TRANS_W*(f-9) +: TRANS_W];
          end
          if (want !== got) begin
            xform_errors++;
            if (xform_errors <= 10) begin
              if (f < 9) begin
                $display("r%0d%0d mismatch: expected %h got %h", f / 3, f % 3, want, got);
              end else begin
                $display("translation %0d mismatch: expected %h got %h", f - 9, want, got);
              end
            end
          end
        end
      end
    end
    if (took_in) begin
      xforms_due = {xforms_due, predict_xform(s_axis_tdata)};
      poses_taken++;
    end
    if (took_in || took_out) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    poses_taken = 0;
    xform_errors = 0;
    stall_cycles = 0;
    calm = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_corner_angles();
    test_translation_passthrough();
    test_random_poses(1300);
    test_back_to_back(430);
    s_axis_tvalid <= 1'b0;
    while (xforms_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (xform_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/ept_pkg.sv
hw/rtl/ept_sincos.sv
hw/rtl/ept_matrix.sv
hw/rtl/euler_pose_to_transform.sv
tb/tb_euler_pose_to_transform.sv
